// ----- hdl/jaos_pkg.sv -----
// jaos_pkg: types, character codes and helpers for the JSON object stream splitter.
// No dependencies. Used by jaos_step, json_array_object_splitter_core and jaos_checker.
package jaos_pkg;

  localparam int unsigned DEPTH_BITS = 8;

  typedef logic [DEPTH_BITS-1:0] depth_t;

  localparam logic [7:0] CH_LBRACKET  = 8'h5B;  // [
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;  // ]
  localparam logic [7:0] CH_LBRACE    = 8'h7B;  // {
  localparam logic [7:0] CH_RBRACE    = 8'h7D;  // }
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       object_last;
    logic       fail_flag;
    logic       done_flag;
  } out_item_t;

  typedef struct packed {
    logic   started;
    logic   array_mode;
    depth_t depth;
    logic   inside_string;
    logic   escape_pending;
    logic   failed;
    logic   finished;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    started:        1'b0,
    array_mode:     1'b0,
    depth:          '0,
    inside_string:  1'b0,
    escape_pending: 1'b0,
    failed:         1'b0,
    finished:       1'b0
  };

  // space, tab, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ----- hdl/jaos_step.sv -----
// jaos_step: per-byte parser update, next state and result item for one byte.
// Depends on jaos_pkg.
module jaos_step import jaos_pkg::*; (
  input  parse_state_t state_i,
  input  logic [7:0]   byte_i,
  output parse_state_t state_o,
  output out_item_t    result_o
);

  logic   fwd;
  logic   last;
  depth_t depth_dec;

  assign depth_dec = state_i.depth - depth_t'(1);

  always_comb begin
    state_o = state_i;
    fwd     = 1'b0;
    last    = 1'b0;
    priority if (state_i.failed || state_i.finished) begin
      // sticky: drop everything
    end else if (!state_i.started) begin
      if (!is_ws(byte_i)) begin
        state_o.started = 1'b1;
        priority if (byte_i == CH_LBRACKET) begin
          state_o.array_mode = 1'b1;
        end else if (byte_i == CH_LBRACE) begin
          state_o.depth = depth_t'(1);
          fwd           = 1'b1;
        end else begin
          state_o.failed = 1'b1;
        end
      end
    end else if (state_i.depth == '0) begin
      // between objects
      priority if (is_ws(byte_i)) begin
      end else if (state_i.array_mode && byte_i == CH_COMMA) begin
      end else if (state_i.array_mode && byte_i == CH_RBRACKET) begin
        state_o.finished = 1'b1;
      end else if (byte_i == CH_LBRACE) begin
        state_o.depth = depth_t'(1);
        fwd           = 1'b1;
      end else begin
        state_o.failed = 1'b1;
      end
    end else if (state_i.inside_string) begin
      fwd = 1'b1;
      priority if (state_i.escape_pending) begin
        state_o.escape_pending = 1'b0;
      end else if (byte_i == CH_BACKSLASH) begin
        state_o.escape_pending = 1'b1;
      end else if (byte_i == CH_QUOTE) begin
        state_o.inside_string = 1'b0;
      end
    end else begin
      priority if (byte_i == CH_QUOTE) begin
        state_o.inside_string = 1'b1;
        fwd                   = 1'b1;
      end else if (byte_i == CH_LBRACE) begin
        if (state_i.depth == '1) begin
          state_o.failed = 1'b1;
        end else begin
          state_o.depth = state_i.depth + depth_t'(1);
          fwd           = 1'b1;
        end
      end else if (byte_i == CH_RBRACE) begin
        state_o.depth = depth_dec;
        fwd           = 1'b1;
        last          = (depth_dec == '0);
      end else begin
        fwd = 1'b1;
      end
    end
  end

  always_comb begin
    result_o.out_byte    = fwd ? byte_i : 8'h00;
    result_o.byte_valid  = fwd;
    result_o.object_last = last;
    result_o.fail_flag   = state_o.failed;
    result_o.done_flag   = state_o.finished;
  end

endmodule

// ----- hdl/json_array_object_splitter_core.sv -----
// json_array_object_splitter_core: top level, input register, parser state and result register.
// Depends on jaos_pkg and jaos_step.
//
// Takes one raw byte per transfer and returns exactly one result per byte, in order: the byte
// itself with byte_valid set when it belongs to a top-level JSON object (object_last marks the
// closing brace), plus the sticky fail and done flags. A byte is held in the input register and
// moves to the result register once that register is empty or its result transfers, and its
// result then shows on the output. With out_ready_i held high, one byte is accepted and one
// result delivered every cycle; the rate is set by the combinational parser state update
// between the two registers. While a result waits on out_ready_i, one more byte can enter the
// input register, and the input then stalls until the result transfers.
// chunk_last is carried in but has no effect on parsing.
module json_array_object_splitter_core import jaos_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic         in_valid_q;
  in_item_t     in_data_q;
  logic         out_valid_q;
  out_item_t    out_data_q;
  parse_state_t state_q, state_d;
  out_item_t    result;
  logic         advance;

  // byte moves from input register to result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  jaos_step u_step (
    .state_i  (state_q),
    .byte_i   (in_data_q.in_byte),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= PARSE_RESET;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hdl/jaos_checker.sv -----
// jaos_checker: port-level assertions for json_array_object_splitter_core, bound to the top.
// Depends on jaos_pkg.
module jaos_checker import jaos_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  logic out_xfer;
  logic seen_fail_q;
  logic seen_done_q;

  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_fail_q <= 1'b0;
      seen_done_q <= 1'b0;
    end else if (out_xfer) begin
      seen_fail_q <= seen_fail_q || out_data_o.fail_flag;
      seen_done_q <= seen_done_q || out_data_o.done_flag;
    end
  end

  // flags never drop once a result has shown them
  a_flags_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!seen_fail_q || out_data_o.fail_flag) &&
                     (!seen_done_q || out_data_o.done_flag)))
    else $error("sticky flag cleared");

  // nothing is forwarded once the stream has failed or finished
  a_no_fwd_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.fail_flag || out_data_o.done_flag)) |->
      (!out_data_o.byte_valid && !out_data_o.object_last))
    else $error("byte forwarded after stop");

  // object end is always a forwarded closing brace, dropped bytes read as zero
  a_last_is_brace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!out_data_o.object_last ||
                      (out_data_o.byte_valid && out_data_o.out_byte == CH_RBRACE)) &&
                     (out_data_o.byte_valid || out_data_o.out_byte == 8'h00)))
    else $error("bad object end or dropped byte not zero");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed while stalled");

  // with no result pending the input is always open
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind json_array_object_splitter_core jaos_checker u_jaos_checker (.*);
